### src/binomial_coefficient_exact_assert.svh
// Assertion macros shared by the binomial coefficient RTL
`ifndef BINOMIAL_COEFFICIENT_EXACT_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_EXACT_ASSERT_SVH

// Same-cycle implication
`define BCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bce_pkg.sv
// Shared constants, controller/datapath structs and the radix-256 divide step
`default_nettype none

package bce_pkg;

  localparam int MAX_N_DEF       = 255;
  localparam int RESULT_BITS_DEF = 32;
  localparam int COEF_W          = 32;
  localparam int ARG_W           = 8;
  localparam int FIRST_FACTOR    = 2;

  typedef struct packed {
    logic load;
    logic step_init;
    logic i_rst;
    logic i_inc;
    logic p1_start;
    logic p1_apply;
    logic p2_iter;
    logic fdiv_start;
    logic fdiv_apply;
    logic finish;
    logic fin_ovf;
  } bce_cmd_t;

  typedef struct packed {
    logic special;
    logic steps_done;
    logic i_le_d;
    logic p1_hit;
    logic div_done;
    logic prod_big;
  } bce_sts_t;

  // Eight restoring divide steps: returns {quotient byte, remainder}.
  // Requires r_in < dvs.
  function automatic logic [2*ARG_W-1:0] step8(input logic [ARG_W-1:0] r_in,
                                                input logic [ARG_W-1:0] bits_in,
                                                input logic [ARG_W-1:0] dvs);
    logic [ARG_W:0]   r;
    logic [ARG_W-1:0] q;
    logic [ARG_W-1:0] bits;
    r    = {1'b0, r_in};
    q    = '0;
    bits = bits_in;
    for (int s = 0; s < ARG_W; s++) begin
      r    = {r[ARG_W-1:0], bits[ARG_W-1]};
      bits = {bits[ARG_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        q = {q[ARG_W-2:0], 1'b1};
      end else begin
        q = {q[ARG_W-2:0], 1'b0};
      end
    end
    return {q, r[ARG_W-1:0]};
  endfunction

endpackage

`default_nettype wire

### src/bce_divider.sv
// Serial divider: wide dividend by 8-bit divisor, one byte per cycle
`default_nettype none

module bce_divider #(
  parameter int DIV_W = 40
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [DIV_W-1:0]          dividend_i,
  input  wire logic [bce_pkg::ARG_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [DIV_W-1:0]               quot_o,
  output logic [bce_pkg::ARG_W-1:0]      rem_o
);
  import bce_pkg::*;

  localparam int NumChunks = DIV_W / ARG_W;
  localparam int CntW      = $clog2(NumChunks + 1);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DIV_W-1:0]    shreg_q;
  logic [ARG_W-1:0]    rem_q;
  logic [ARG_W-1:0]    dvs_q;
  logic [2*ARG_W-1:0]  stp;

  assign stp = step8(rem_q, shreg_q[DIV_W-1 -: ARG_W], dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumChunks);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bytes shift in from the bottom as dividend bytes leave the top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shreg_q <= dividend_i;
      rem_q   <= '0;
      dvs_q   <= divisor_i;
    end else if (busy_q) begin
      shreg_q <= {shreg_q[DIV_W-ARG_W-1:0], stp[2*ARG_W-1:ARG_W]};
      rem_q   <= stp[ARG_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = shreg_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### src/bce_datapath.sv
// Datapath: running total, step counters, factor cancellation, multiply and divide
`default_nettype none

module bce_datapath #(
  parameter int MAX_N       = bce_pkg::MAX_N_DEF,
  parameter int RESULT_BITS = bce_pkg::RESULT_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [bce_pkg::ARG_W-1:0] n_total_i,
  input  wire logic [bce_pkg::ARG_W-1:0] k_choose_i,
  input  wire bce_pkg::bce_cmd_t         cmd_i,
  output bce_pkg::bce_sts_t              sts_o,
  output logic [bce_pkg::COEF_W-1:0]     coefficient_o,
  output logic                           overflow_o
);
  import bce_pkg::*;

  localparam int TotW = RESULT_BITS;
  localparam int ProdW = RESULT_BITS + ARG_W;
  localparam int DivW = ((ProdW + ARG_W - 1) / ARG_W) * ARG_W;

  logic [TotW-1:0]    total_q;
  logic [ProdW-1:0]   prod_q;
  logic [ARG_W-1:0]   mult_q, m_q, d_q, i_q, j_q, steps_q;
  logic               special_q, range_err_q;
  logic [COEF_W-1:0]  coef_q;
  logic               ovf_q;

  logic [ARG_W-1:0]   nmk;
  logic               range_err;
  logic [2*ARG_W-1:0] d_qr, m_qr;
  logic [ARG_W-1:0]   d_quot, d_rem, m_quot, m_rem;

  logic               div_start;
  logic [DivW-1:0]    div_dividend;
  logic [ARG_W-1:0]   div_divisor;
  logic               div_done;
  logic [DivW-1:0]    div_quot;
  logic [ARG_W-1:0]   div_rem;

  assign nmk       = n_total_i - k_choose_i;
  assign range_err = n_total_i > ARG_W'(MAX_N);

  assign d_qr   = step8('0, d_q, i_q);
  assign m_qr   = step8('0, m_q, i_q);
  assign d_quot = d_qr[2*ARG_W-1:ARG_W];
  assign d_rem  = d_qr[ARG_W-1:0];
  assign m_quot = m_qr[2*ARG_W-1:ARG_W];
  assign m_rem  = m_qr[ARG_W-1:0];

  assign div_start    = cmd_i.p1_start | cmd_i.fdiv_start;
  assign div_dividend = cmd_i.fdiv_start ? DivW'(prod_q) : DivW'(total_q);
  assign div_divisor  = cmd_i.fdiv_start ? d_q : i_q;

  bce_divider #(
    .DIV_W(DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      total_q     <= TotW'(1);
      j_q         <= ARG_W'(1);
      mult_q      <= n_total_i;
      steps_q     <= (k_choose_i < nmk) ? k_choose_i : nmk;
      range_err_q <= range_err;
      special_q   <= range_err || (k_choose_i > n_total_i);
    end
    if (cmd_i.step_init) begin
      m_q <= mult_q;
      d_q <= j_q;
      i_q <= ARG_W'(FIRST_FACTOR);
    end
    if (cmd_i.i_rst) begin
      i_q <= ARG_W'(FIRST_FACTOR);
    end
    if (cmd_i.i_inc) begin
      i_q <= i_q + ARG_W'(1);
    end
    // factor i divides the divisor; it cancels if it also divides the total
    if (cmd_i.p1_apply) begin
      if (div_rem == '0) begin
        total_q <= div_quot[TotW-1:0];
        d_q     <= d_quot;
      end
      i_q <= i_q + ARG_W'(1);
    end
    if (cmd_i.p2_iter) begin
      if (d_rem == '0 && m_rem == '0) begin
        m_q <= m_quot;
        d_q <= d_quot;
      end
      i_q <= i_q + ARG_W'(1);
    end
    // product taken when the second pass ends
    if (cmd_i.p2_iter == 1'b0 && cmd_i.i_rst == 1'b0 && cmd_i.fdiv_start == 1'b0
        && cmd_i.fin_ovf == 1'b0) begin
      prod_q <= ProdW'(total_q) * ProdW'(m_q);
    end
    if (cmd_i.fdiv_apply) begin
      total_q <= div_quot[TotW-1:0];
      j_q     <= j_q + ARG_W'(1);
      mult_q  <= mult_q - ARG_W'(1);
    end
    if (cmd_i.finish) begin
      coef_q <= (special_q || cmd_i.fin_ovf) ? '0 : COEF_W'(total_q);
      ovf_q  <= range_err_q || cmd_i.fin_ovf;
    end
  end

  assign sts_o.special    = special_q;
  assign sts_o.steps_done = j_q > steps_q;
  assign sts_o.i_le_d     = i_q <= d_q;
  assign sts_o.p1_hit     = d_rem == '0;
  assign sts_o.div_done   = div_done;
  assign sts_o.prod_big   = |prod_q[ProdW-1:TotW];

  assign coefficient_o = coef_q;
  assign overflow_o    = ovf_q;

endmodule

`default_nettype wire

### src/bce_ctrl.sv
// Controller: sequences steps, cancellation passes and divides
`default_nettype none

`include "binomial_coefficient_exact_assert.svh"

module bce_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire bce_pkg::bce_sts_t sts_i,
  output bce_pkg::bce_cmd_t      cmd_o,
  output logic                   busy_o,
  output logic                   valid_o
);
  import bce_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_P1    = 3'd2;
  localparam logic [2:0] S_P1W   = 3'd3;
  localparam logic [2:0] S_P2    = 3'd4;
  localparam logic [2:0] S_OCHK  = 3'd5;
  localparam logic [2:0] S_FDIV  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       valid_q, valid_d;
  bce_cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.load = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.special || sts_i.steps_done) begin
          cmd.finish = 1'b1;
          valid_d    = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd.step_init = 1'b1;
          state_d       = S_P1;
        end
      end
      S_P1: begin
        if (!sts_i.i_le_d) begin
          cmd.i_rst = 1'b1;
          state_d   = S_P2;
        end else if (sts_i.p1_hit) begin
          cmd.p1_start = 1'b1;
          state_d      = S_P1W;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_P1W: begin
        if (sts_i.div_done) begin
          cmd.p1_apply = 1'b1;
          state_d      = S_P1;
        end
      end
      S_P2: begin
        if (sts_i.i_le_d) begin
          cmd.p2_iter = 1'b1;
        end else begin
          state_d = S_OCHK;
        end
      end
      S_OCHK: begin
        if (sts_i.prod_big) begin
          cmd.finish  = 1'b1;
          cmd.fin_ovf = 1'b1;
          valid_d     = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cmd.fdiv_start = 1'b1;
          state_d        = S_FDIV;
        end
      end
      S_FDIV: begin
        if (sts_i.div_done) begin
          cmd.fdiv_apply = 1'b1;
          state_d        = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign cmd_o   = cmd;
  assign busy_o  = state_q != S_IDLE;
  assign valid_o = valid_q;

  `BCE_ASSERT_SAME(a_div_done_waiting, clk_i, rst_ni, sts_i.div_done, (state_q == S_P1W || state_q == S_FDIV), "divider done outside a wait state")

endmodule

`default_nettype wire

### src/binomial_coefficient_exact.sv
// Top level: exact binomial coefficient C(n,k), controller plus datapath
//
//  channel  | signals                      | transfer
//  ---------+------------------------------+------------------------------
//  request  | n_total_i, k_choose_i        | start high while busy low
//  result   | coefficient_o, overflow_o    | valid_o high for one cycle
//
// One request at a time. With k' = min(k, n-k), the result takes k' steps, each a serial
// trial-division loop plus divides on the shared byte-per-cycle divider, which set the
// time to the result; special cases (n above MAX_N, k above n) skip the steps.
// Asynchronous active-low reset returns to idle. The result is shown for exactly one cycle;
// the receiver cannot stall.
`default_nettype none

`include "binomial_coefficient_exact_assert.svh"

module binomial_coefficient_exact #(
  parameter int MAX_N       = bce_pkg::MAX_N_DEF,
  parameter int RESULT_BITS = bce_pkg::RESULT_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [bce_pkg::ARG_W-1:0] n_total_i,
  input  wire logic [bce_pkg::ARG_W-1:0] k_choose_i,
  output logic                           valid_o,
  output logic [bce_pkg::COEF_W-1:0]     coefficient_o,
  output logic                           overflow_o
);
  import bce_pkg::*;

  bce_cmd_t cmd;
  bce_sts_t sts;

  bce_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .valid_o (valid_o)
  );

  bce_datapath #(
    .MAX_N       (MAX_N),
    .RESULT_BITS (RESULT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_total_i     (n_total_i),
    .k_choose_i    (k_choose_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .coefficient_o (coefficient_o),
    .overflow_o    (overflow_o)
  );

  `BCE_ASSERT_SAME(a_valid_idle, clk_i, rst_ni, valid_o, !busy, "result shown while busy")
  `BCE_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, (start && !busy), busy, "accepted request did not raise busy")
  `BCE_ASSERT_SAME(a_ovf_zero, clk_i, rst_ni, (valid_o && overflow_o), (coefficient_o == '0), "overflow with nonzero coefficient")

endmodule

`default_nettype wire

### sim/binomial_coefficient_exact_tb.sv
// Self-checking testbench for binomial_coefficient_exact: directed and random requests
module binomial_coefficient_exact_tb;

  localparam int          WATCHDOG_LIMIT = 100000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [63:0] COEF_LIMIT     = (64'd1 << bce_pkg::RESULT_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic [bce_pkg::COEF_W-1:0] coef;
    logic                       ovf;
  } binom_res_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [bce_pkg::ARG_W-1:0] n_total_i;
  logic [bce_pkg::ARG_W-1:0] k_choose_i;
  logic                      valid_o;
  logic [bce_pkg::COEF_W-1:0] coefficient_o;
  logic                      overflow_o;

  binom_res_t pending_coef_q[$];
  int         mismatches   = 0;
  int         idle_cycles  = 0;
  bit         steady_sender = 1'b0;

  binomial_coefficient_exact u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .n_total_i     (n_total_i),
    .k_choose_i    (k_choose_i),
    .valid_o       (valid_o),
    .coefficient_o (coefficient_o),
    .overflow_o    (overflow_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // one trial-division pass over 2..den, cancelling factors shared by num and den
  function automatic void cancel_common_factors(inout logic [63:0] num, inout logic [63:0] den);
    logic [63:0] f;
    f = 64'd2;
    while (f <= den) begin
      if ((num % f) == 0 && (den % f) == 0) begin
        num = num / f;
        den = den / f;
      end
      f++;
    end
  endfunction

  function automatic binom_res_t predict_binomial(input logic [bce_pkg::ARG_W-1:0] n,
                                                   input logic [bce_pkg::ARG_W-1:0] k);
    binom_res_t  res;
    logic [63:0] total;
    logic [63:0] mult;
    logic [63:0] steps;
    logic [63:0] m;
    logic [63:0] d;
    res = '0;
    if (int'(n) > bce_pkg::MAX_N_DEF) begin
      res.ovf = 1'b1;
      return res;
    end
    if (k > n) return res;
    steps = (k < (n - k)) ? 64'(k) : 64'(n - k);
    total = 64'd1;
    mult  = 64'(n);
    for (logic [63:0] j = 1; j <= steps; j++) begin
      m = mult;
      d = j;
      cancel_common_factors(total, d);
      cancel_common_factors(m, d);
      if (m > COEF_LIMIT / total) begin
        res.ovf = 1'b1;
        return res;
      end
      total = (total * m) / d;
      mult--;
    end
    res.coef = total[bce_pkg::COEF_W-1:0];
    return res;
  endfunction

  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start      = 1'b0;
      n_total_i  = bce_pkg::ARG_W'($urandom);
      k_choose_i = bce_pkg::ARG_W'($urandom);
    end
  endtask

  task automatic send_request(input logic [bce_pkg::ARG_W-1:0] n,
                              input logic [bce_pkg::ARG_W-1:0] k);
    if (!steady_sender && $urandom_range(99) < 25) idle_gap($urandom_range(1, 6));
    @(negedge clk_i);
    start      = 1'b1;
    n_total_i  = n;
    k_choose_i = k;
    do @(posedge clk_i); while (busy);
    pending_coef_q.push_back(predict_binomial(n, k));
  endtask

  task automatic wait_drained();
    while (pending_coef_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_edges();
    send_request(8'd0,   8'd0);
    send_request(8'd0,   8'd255);
    send_request(8'd1,   8'd0);
    send_request(8'd1,   8'd1);
    send_request(8'd2,   8'd1);
    send_request(8'd255, 8'd0);
    send_request(8'd255, 8'd255);
    send_request(8'd255, 8'd1);
    send_request(8'd255, 8'd254);
    send_request(8'd255, 8'd128);
    send_request(8'd254, 8'd127);
    send_request(8'd34,  8'd17);
    send_request(8'd33,  8'd17);
    send_request(8'd35,  8'd17);
    send_request(8'd36,  8'd18);
    send_request(8'd10,  8'd3);
    send_request(8'd10,  8'd7);
    send_request(8'd100, 8'd3);
    send_request(8'd200, 8'd5);
    send_request(8'd7,   8'd200);
    send_request(8'd128, 8'd127);
    send_request(8'd68,  8'd34);
  endtask

  // sender pauses after every third request until every outstanding result is back
  task automatic test_pause_until_drained();
    for (int i = 0; i < 10; i++) begin
      send_request(8'($urandom_range(40)), 8'($urandom_range(40)));
      if (i % 3 == 2) begin
        @(negedge clk_i);
        start = 1'b0;
        wait_drained();
        idle_gap($urandom_range(1, 8));
      end
    end
  endtask

  task automatic test_random_in_range(input int count);
    logic [bce_pkg::ARG_W-1:0] n;
    for (int i = 0; i < count; i++) begin
      n = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
      send_request(n, 8'($urandom_range(n)));
    end
  endtask

  task automatic test_random_back_to_back(input int count);
    steady_sender = 1'b1;
    test_random_in_range(count);
    steady_sender = 1'b0;
  endtask

  task automatic test_random_any(input int count);
    for (int i = 0; i < count; i++) send_request(8'($urandom), 8'($urandom));
  endtask

  always @(posedge clk_i) begin
    binom_res_t exp_res;
    if (rst_ni && valid_o) begin
      if (pending_coef_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: coefficient %0d overflow %0b", coefficient_o, overflow_o);
      end else begin
        exp_res = pending_coef_q.pop_front();
        if (coefficient_o !== exp_res.coef || overflow_o !== exp_res.ovf) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected coefficient %0d overflow %0b, got %0d overflow %0b",
                     exp_res.coef, exp_res.ovf, coefficient_o, overflow_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", pending_coef_q.size());
        $display("binomial_coefficient_exact_tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    n_total_i  = '0;
    k_choose_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_edges();
    test_pause_until_drained();
    test_random_in_range(110);
    test_random_back_to_back(60);
    test_random_any(90);

    @(negedge clk_i);
    start = 1'b0;
    wait_drained();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && pending_coef_q.size() == 0) begin
      $display("binomial_coefficient_exact_tb passed");
    end else begin
      $display("binomial_coefficient_exact_tb failed");
    end
    $finish;
  end

endmodule
